// ----- design/usbhc_pkg.sv -----
// Package for the USB host controller register block.
// Request and response types, register offsets and bit masks.
// No dependencies.
`default_nettype none

package usbhc_pkg;

   localparam logic [1:0] KIND_READ  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_TICK  = 2'd2;

   localparam logic [4:0] OFF_CMD     = 5'h00;
   localparam logic [4:0] OFF_STS     = 5'h02;
   localparam logic [4:0] OFF_IEN     = 5'h04;
   localparam logic [4:0] OFF_FRNUM   = 5'h06;
   localparam logic [4:0] OFF_FLBASE  = 5'h08;
   localparam logic [4:0] OFF_SOF     = 5'h0C;
   localparam logic [4:0] OFF_PORT_LO = 5'h10;
   localparam logic [4:0] OFF_PORT_HI = 5'h1E;

   localparam logic [5:0] WINDOW_BYTES = 6'd32;
   localparam logic [2:0] MAX_SIZE     = 3'd4;

   localparam logic [15:0] STS_HALTED    = 16'h0020;
   localparam logic [15:0] PORT_CCS      = 16'h0001;
   localparam logic [15:0] PORT_CSC      = 16'h0002;
   localparam logic [15:0] PORT_EN       = 16'h0004;
   localparam logic [15:0] PORT_RO_MASK  = 16'h01BB;
   localparam logic [15:0] PORT_WC_MASK  = 16'h000A;
   localparam logic [15:0] PORT_SC_RESET = 16'h0080;
   localparam logic [7:0]  SOF_RESET     = 8'd64;

   localparam int PORT_PR_BIT = 9;

   typedef struct packed {
      logic [1:0]  kind;
      logic [4:0]  offset;
      logic [2:0]  access_size;
      logic [31:0] write_data;
      logic        tick_interrupt;
      logic        tick_error;
   } item_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        irq_level;
      logic        frames_running;
      logic [7:0]  port_reset_pulse;
      logic        bad_access;
   } result_type;

endpackage

`default_nettype wire

// ----- design/usbhc_regs.sv -----
// Register state and per-request update for the USB host controller block.
// Reads, writes and frame ticks are resolved in one pass; uses usbhc_pkg.
`default_nettype none

module usbhc_regs
   import usbhc_pkg::*;
#(
   parameter int PORT_COUNT = 2
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       proc,
   input  wire item_type   item,
   input  wire logic       csr_we,
   input  wire logic [7:0] csr_wdata,
   output result_type      result
);

   logic [7:0]  attached_ff;
   logic [15:0] cmd_ff, cmd_in;
   logic [15:0] sts_ff, sts_in;
   logic [15:0] ien_ff, ien_in;
   logic [15:0] frame_ff, frame_in;
   logic [31:0] flbase_ff, flbase_in;
   logic [7:0]  sof_ff, sof_in;
   logic        running_ff, running_in;
   logic [15:0] psc_ff [PORT_COUNT];
   logic [15:0] psc_in [PORT_COUNT];

   logic [2:0]   size;
   logic [31:0]  wval;
   logic [15:0]  half;
   logic [5:0]   rd_end;
   logic [255:0] window;
   logic [31:0]  rdata;
   logic [7:0]   pulse;
   logic         bad;
   logic [4:0]   rd_addr [4];

   function automatic logic [15:0] port_write(input logic [15:0] sc, input logic [15:0] v);
      logic [15:0] ro;
      logic [15:0] vv;
      ro = sc & PORT_RO_MASK;
      vv = v;
      if (!ro[0]) vv = vv & ~PORT_EN;
      return (ro | (vv & ~PORT_RO_MASK)) & ~(vv & PORT_WC_MASK);
   endfunction

   // Byte view of the I/O window
   always_comb begin
      window = '0;
      window[15:0]    = cmd_ff;
      window[31:16]   = sts_ff;
      window[47:32]   = ien_ff;
      window[63:48]   = frame_ff;
      window[95:64]   = flbase_ff;
      window[103:96]  = sof_ff;
      for (int i = 0; i < PORT_COUNT; i++) begin
         window[128 + 16*i +: 16] = psc_ff[i];
      end
   end

   always_comb begin
      size = (item.access_size > MAX_SIZE) ? MAX_SIZE : item.access_size;
      case (size)
         3'd0:    wval = '0;
         3'd1:    wval = {24'b0, item.write_data[7:0]};
         3'd2:    wval = {16'b0, item.write_data[15:0]};
         3'd3:    wval = {8'b0, item.write_data[23:0]};
         default: wval = item.write_data;
      endcase
      half   = wval[15:0];
      rd_end = {1'b0, item.offset} + {3'b0, size};

      cmd_in     = cmd_ff;
      sts_in     = sts_ff;
      ien_in     = ien_ff;
      frame_in   = frame_ff;
      flbase_in  = flbase_ff;
      sof_in     = sof_ff;
      running_in = running_ff;
      for (int i = 0; i < PORT_COUNT; i++) psc_in[i] = psc_ff[i];
      rdata = '0;
      pulse = '0;
      bad   = 1'b0;
      for (int k = 0; k < 4; k++) rd_addr[k] = item.offset + 5'(k);

      case (item.kind)
         KIND_READ: begin
            if (rd_end > WINDOW_BYTES) begin
               bad = 1'b1;
            end else begin
               for (int k = 0; k < 4; k++) begin
                  if (3'(k) < size) rdata[8*k +: 8] = window[{rd_addr[k], 3'b000} +: 8];
               end
            end
         end
         KIND_WRITE: begin
            case (item.offset)
               OFF_CMD: begin
                  if (half[0] && !cmd_ff[0]) begin
                     running_in = 1'b1;
                     sts_in     = sts_ff & ~STS_HALTED;
                  end else if (!half[0]) begin
                     running_in = 1'b0;
                     sts_in     = sts_ff | STS_HALTED;
                  end
                  if (half[2] || half[1]) begin
                     // global or host controller reset
                     cmd_in     = '0;
                     sts_in     = STS_HALTED;
                     ien_in     = '0;
                     frame_in   = '0;
                     flbase_in  = '0;
                     sof_in     = SOF_RESET;
                     running_in = 1'b0;
                     for (int i = 0; i < PORT_COUNT; i++) begin
                        psc_in[i] = attached_ff[i] ? (PORT_SC_RESET | PORT_CCS | PORT_CSC)
                                                   : PORT_SC_RESET;
                     end
                  end else begin
                     cmd_in = half;
                  end
               end
               OFF_STS:    sts_in = sts_ff & ~half;
               OFF_IEN:    ien_in = half;
               OFF_FRNUM:  if (sts_ff[5]) frame_in = half;
               OFF_FLBASE: flbase_in = wval;
               OFF_SOF:    sof_in = wval[7:0];
               default: begin
                  if (item.offset inside {[OFF_PORT_LO:OFF_PORT_HI]}) begin
                     for (int i = 0; i < PORT_COUNT; i++) begin
                        if (item.offset[3:1] == 3'(i)) begin
                           psc_in[i] = port_write(psc_ff[i], half);
                           pulse[i]  = half[PORT_PR_BIT] && !psc_ff[i][PORT_PR_BIT]
                                       && attached_ff[i];
                        end
                     end
                  end else begin
                     bad = 1'b1;
                  end
               end
            endcase
         end
         KIND_TICK: begin
            if (running_ff) begin
               sts_in   = sts_ff | {14'b0, item.tick_error, item.tick_interrupt};
               frame_in = frame_ff + 16'd1;
            end
         end
         default: ;
      endcase

      result.read_data        = rdata;
      result.irq_level        = ((ien_in[3:2] != 2'b00) && sts_in[0])
                                || (ien_in[0] && sts_in[1])
                                || (ien_in[1] && sts_in[2])
                                || sts_in[3] || sts_in[4];
      result.frames_running   = running_in;
      result.port_reset_pulse = pulse;
      result.bad_access       = bad;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attached_ff <= '0;
      end else if (csr_we) begin
         attached_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff     <= '0;
         sts_ff     <= STS_HALTED;
         ien_ff     <= '0;
         frame_ff   <= '0;
         flbase_ff  <= '0;
         sof_ff     <= SOF_RESET;
         running_ff <= 1'b0;
         for (int i = 0; i < PORT_COUNT; i++) psc_ff[i] <= PORT_SC_RESET;
      end else if (proc) begin
         cmd_ff     <= cmd_in;
         sts_ff     <= sts_in;
         ien_ff     <= ien_in;
         frame_ff   <= frame_in;
         flbase_ff  <= flbase_in;
         sof_ff     <= sof_in;
         running_ff <= running_in;
         for (int i = 0; i < PORT_COUNT; i++) psc_ff[i] <= psc_in[i];
      end
   end

`ifndef NO_ASSERTIONS
   a_run_not_halted: assert property (@(posedge clock) disable iff (reset)
      running_ff |-> !sts_ff[5])
      else $error("running while halted bit set");

   a_pulse_single: assert property (@(posedge clock) disable iff (reset)
      $onehot0(result.port_reset_pulse))
      else $error("more than one port reset pulse");

   a_tick_stopped: assert property (@(posedge clock) disable iff (reset)
      proc && item.kind == KIND_TICK && !running_ff |=> $stable(frame_ff))
      else $error("frame counter moved while stopped");

   a_bad_kind: assert property (@(posedge clock) disable iff (reset)
      result.bad_access |-> (item.kind == KIND_READ || item.kind == KIND_WRITE))
      else $error("bad access on tick");
`endif

endmodule

`default_nettype wire

// ----- design/usb_host_controller_register_block_core.sv -----
// Top level of the USB host controller register block.
// Request register, usbhc_regs update logic and response register; uses usbhc_pkg.
// Both ends are registered: an accepted request passes the request register, then the response register.
// Throughput: one request per cycle while the response is not held by rsp_tready; the update is one combinational pass.
// Reset: synchronous, clears valid flags and controller registers; halted set, frame timing 64, ports 0x0080.
`default_nettype none

module usb_host_controller_register_block_core
   import usbhc_pkg::*;
#(
   parameter int PORT_COUNT = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // offset[4:0], access_size[7:5], write_data[39:8], tick_interrupt[40], tick_error[41]
   input  wire logic [47:0] req_tdata,
   // kind[1:0]
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // read_data[31:0], irq_level[32], frames_running[33], port_reset_pulse[41:34],
   // bad_access[42]
   output logic [47:0]      rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic [7:0]  csr_wdata
);

   logic       in_vld_ff;
   item_type   in_ff;
   logic       out_vld_ff;
   result_type out_ff;
   logic       out_free;
   logic       proc;
   result_type result;

   assign out_free   = !out_vld_ff || rsp_tready;
   assign proc       = in_vld_ff && out_free;
   assign req_tready = !in_vld_ff || out_free;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {5'b0, out_ff.bad_access, out_ff.port_reset_pulse,
                        out_ff.frames_running, out_ff.irq_level, out_ff.read_data};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_ff.kind           <= req_tuser;
         in_ff.offset         <= req_tdata[4:0];
         in_ff.access_size    <= req_tdata[7:5];
         in_ff.write_data     <= req_tdata[39:8];
         in_ff.tick_interrupt <= req_tdata[40];
         in_ff.tick_error     <= req_tdata[41];
      end
   end

   usbhc_regs #(
      .PORT_COUNT(PORT_COUNT)
   ) u_regs (
      .clock     (clock),
      .reset     (reset),
      .proc      (proc),
      .item      (in_ff),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (out_free) begin
         out_vld_ff <= proc;
      end
   end

   always_ff @(posedge clock) begin
      if (proc) begin
         out_ff <= result;
      end
   end

endmodule

`default_nettype wire
